### hdl/gwsc_pkg.sv
package gwsc_pkg;

  localparam int unsigned WEEK_W = 10;
  localparam int unsigned SECS_W = 20;
  localparam int unsigned OFFSET_W = 8;

  localparam logic [13:0] WEEK_ROLLOVER = 14'd1024;
  localparam logic [13:0] DAYS_IN_WEEK = 14'd7;
  localparam logic [13:0] START_DAY = 14'd5;
  localparam logic [11:0] BASE_YEAR = 12'd1980;
  localparam int unsigned MONTHS = 12;

  // Constant divisions are done as a multiply by a truncated reciprocal.
  // Over the operand ranges used here, the estimate is never high and at
  // most one below the true quotient, so one compare and subtract fixes it.
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [3:0] DAY_RECIP = 4'd12;
  localparam int unsigned DAY_SHIFT = 20;

  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
  localparam logic [8:0] HOUR_RECIP = 9'd291;
  localparam int unsigned HOUR_SHIFT = 20;

  localparam logic [5:0] SEC_PER_MIN = 6'd60;
  localparam logic [10:0] MIN_RECIP = 11'd1092;
  localparam int unsigned MIN_SHIFT = 16;

  localparam logic [8:0] DAYS_IN_YEAR = 9'd365;
  localparam logic [8:0] DAYS_IN_LEAP = 9'd366;
  localparam logic [11:0] YEAR_RECIP = 12'd2872;
  localparam int unsigned YEAR_SHIFT = 20;

  typedef struct packed {
    logic        tv;
    logic [9:0]  week;
    logic [3:0]  wday;
    logic [16:0] sod;
  } day_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic        tv;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
  } date_t;

  // Days before the start of a month, by month index from 0 to 12.
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] days;
    case (idx)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      4'd12:   days = 9'd365;
      default: days = 9'd0;
    endcase
    if (leap && idx >= 4'd2 && idx <= 4'd12) begin
      days = days + 9'd1;
    end
    return days;
  endfunction

endpackage

### hdl/gps_week_seconds_to_calendar_unit.sv
// GPS week and time of week to UTC calendar date and time.
//
// Input: raise start with week_number_i, week_seconds_i and utc_offset_i;
// the beat is taken at a rising edge where start is high and busy is low.
// busy stays low, so a new beat may be started in every cycle.
//
// Output: each beat gives one result, shown for one cycle with done_o high.
// time_valid_o is low when the offset exceeds the seconds; all calendar
// fields are then zero. The receiver cannot hold results off.
//
// Throughput is one beat per cycle. From the accepting edge to the edge that
// takes the result, the pipeline runs as follows: four stages split the
// seconds into day of week and second of day, seven stages derive year,
// month and day in parallel with the hour, minute and second, and one
// output register.
//
// Reset clears the valid bits of every stage, so beats in flight are lost
// and no result appears until new beats come through.
module gps_week_seconds_to_calendar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  week_number_i,
  input  logic [19:0] week_seconds_i,
  input  logic [7:0]  utc_offset_i,
  output logic        done_o,
  output logic        time_valid_o,
  output logic [11:0] cal_year_o,
  output logic [3:0]  cal_month_o,
  output logic [4:0]  cal_day_o,
  output logic [4:0]  cal_hour_o,
  output logic [5:0]  cal_minute_o,
  output logic [5:0]  cal_second_o
);
  import gwsc_pkg::*;

  logic  accept;
  logic  day_vld;
  day_t  day;
  logic  hms_vld;
  hms_t  hms;
  logic  date_vld;
  date_t date;

  logic  hms_vld_q;
  hms_t  hms_q;

  logic        done_q;
  logic        tv_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  mday_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  gwsc_daysplit u_daysplit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .week_i   (week_number_i),
    .secs_i   (week_seconds_i),
    .offset_i (utc_offset_i),
    .valid_o  (day_vld),
    .day_o    (day)
  );

  gwsc_hms u_hms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_vld),
    .sod_i   (day.sod),
    .valid_o (hms_vld),
    .hms_o   (hms)
  );

  gwsc_ymd u_ymd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_vld),
    .tv_i    (day.tv),
    .week_i  (day.week),
    .wday_i  (day.wday),
    .valid_o (date_vld),
    .date_o  (date)
  );

  // The time of day is ready one stage ahead of the date.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hms_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      hms_vld_q <= hms_vld;
      done_q    <= date_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    hms_q <= hms;
  end

  always_ff @(posedge clk_i) begin
    tv_q <= date.tv;
    if (date.tv) begin
      year_q   <= date.year;
      month_q  <= date.month;
      mday_q   <= date.mday;
      hour_q   <= hms_q.hour;
      minute_q <= hms_q.minute;
      second_q <= hms_q.second;
    end else begin
      year_q   <= '0;
      month_q  <= '0;
      mday_q   <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
    end
  end

  assign done_o       = done_q;
  assign time_valid_o = tv_q;
  assign cal_year_o   = year_q;
  assign cal_month_o  = month_q;
  assign cal_day_o    = mday_q;
  assign cal_hour_o   = hour_q;
  assign cal_minute_o = minute_q;
  assign cal_second_o = second_q;

  a_paths_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hms_vld_q == date_vld)
    else $error("time of day and date paths out of step");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 12))
    else $error("result without a beat taken twelve cycles before");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !time_valid_o) |->
      (cal_year_o == 12'd0 && cal_month_o == 4'd0 && cal_day_o == 5'd0 &&
       cal_hour_o == 5'd0 && cal_minute_o == 6'd0 && cal_second_o == 6'd0))
    else $error("invalid time with nonzero calendar fields");

  a_tod_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && time_valid_o) |->
      (cal_hour_o < 5'd24 && cal_minute_o < 6'd60 && cal_second_o < 6'd60 &&
       cal_month_o >= 4'd1 && cal_month_o <= 4'd12 && cal_day_o >= 5'd1))
    else $error("calendar field out of range");

endmodule

### hdl/gwsc_daysplit.sv
module gwsc_daysplit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [9:0]          week_i,
  input  logic [19:0]         secs_i,
  input  logic [7:0]          offset_i,
  output logic                valid_o,
  output gwsc_pkg::day_t      day_o
);
  import gwsc_pkg::*;

  logic [3:0]  vld_q;

  logic [20:0] diff_d;
  logic        s1_tv_q;
  logic [9:0]  s1_week_q;
  logic [19:0] s1_d_q;

  logic [23:0] day_prod;
  logic        s2_tv_q;
  logic [9:0]  s2_week_q;
  logic [19:0] s2_d_q;
  logic [3:0]  s2_qe_q;

  logic [20:0] rem_full;
  logic        s3_tv_q;
  logic [9:0]  s3_week_q;
  logic [3:0]  s3_qe_q;
  logic [17:0] s3_r_q;

  logic        fix_day;
  logic        s4_tv_q;
  logic [9:0]  s4_week_q;
  logic [3:0]  s4_wday_q;
  logic [16:0] s4_sod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // Stage 1: remove the leap seconds. A borrow marks the time invalid.
  assign diff_d = {1'b0, secs_i} - {13'd0, offset_i};

  always_ff @(posedge clk_i) begin
    s1_tv_q   <= ~diff_d[20];
    s1_week_q <= week_i;
    s1_d_q    <= diff_d[19:0];
  end

  // Stage 2: estimate of the day of the week.
  assign day_prod = {4'd0, s1_d_q} * {20'd0, DAY_RECIP};

  always_ff @(posedge clk_i) begin
    s2_tv_q   <= s1_tv_q;
    s2_week_q <= s1_week_q;
    s2_d_q    <= s1_d_q;
    s2_qe_q   <= day_prod[DAY_SHIFT +: 4];
  end

  // Stage 3: remainder against the estimate, below two days.
  assign rem_full = {1'b0, s2_d_q} - {17'd0, s2_qe_q} * {4'd0, SEC_PER_DAY};

  always_ff @(posedge clk_i) begin
    s3_tv_q   <= s2_tv_q;
    s3_week_q <= s2_week_q;
    s3_qe_q   <= s2_qe_q;
    s3_r_q    <= rem_full[17:0];
  end

  // Stage 4: correct the estimate by one day where needed.
  assign fix_day = s3_r_q >= {1'b0, SEC_PER_DAY};

  always_ff @(posedge clk_i) begin
    s4_tv_q   <= s3_tv_q;
    s4_week_q <= s3_week_q;
    if (fix_day) begin
      s4_wday_q <= s3_qe_q + 4'd1;
      s4_sod_q  <= 17'(s3_r_q - {1'b0, SEC_PER_DAY});
    end else begin
      s4_wday_q <= s3_qe_q;
      s4_sod_q  <= s3_r_q[16:0];
    end
  end

  assign valid_o   = vld_q[3];
  assign day_o.tv   = s4_tv_q;
  assign day_o.week = s4_week_q;
  assign day_o.wday = s4_wday_q;
  assign day_o.sod  = s4_sod_q;

endmodule

### hdl/gwsc_hms.sv
module gwsc_hms (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [16:0]    sod_i,
  output logic           valid_o,
  output gwsc_pkg::hms_t hms_o
);
  import gwsc_pkg::*;

  logic [5:0]  vld_q;

  logic [25:0] hour_prod;
  logic [16:0] h1_sod_q;
  logic [4:0]  h1_he_q;

  logic [16:0] hour_rem;
  logic [4:0]  h2_he_q;
  logic [12:0] h2_r_q;

  logic [4:0]  h3_hour_q;
  logic [11:0] h3_r_q;

  logic [22:0] min_prod;
  logic [4:0]  h4_hour_q;
  logic [11:0] h4_r_q;
  logic [5:0]  h4_me_q;

  logic [11:0] min_rem;
  logic [4:0]  h5_hour_q;
  logic [5:0]  h5_me_q;
  logic [6:0]  h5_r_q;

  logic [4:0]  h6_hour_q;
  logic [5:0]  h6_min_q;
  logic [5:0]  h6_sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign hour_prod = {9'd0, sod_i} * {17'd0, HOUR_RECIP};

  always_ff @(posedge clk_i) begin
    h1_sod_q <= sod_i;
    h1_he_q  <= hour_prod[HOUR_SHIFT +: 5];
  end

  assign hour_rem = h1_sod_q - {12'd0, h1_he_q} * {5'd0, SEC_PER_HOUR};

  always_ff @(posedge clk_i) begin
    h2_he_q <= h1_he_q;
    h2_r_q  <= hour_rem[12:0];
  end

  always_ff @(posedge clk_i) begin
    if (h2_r_q >= {1'b0, SEC_PER_HOUR}) begin
      h3_hour_q <= h2_he_q + 5'd1;
      h3_r_q    <= 12'(h2_r_q - {1'b0, SEC_PER_HOUR});
    end else begin
      h3_hour_q <= h2_he_q;
      h3_r_q    <= h2_r_q[11:0];
    end
  end

  assign min_prod = {11'd0, h3_r_q} * {12'd0, MIN_RECIP};

  always_ff @(posedge clk_i) begin
    h4_hour_q <= h3_hour_q;
    h4_r_q    <= h3_r_q;
    h4_me_q   <= min_prod[MIN_SHIFT +: 6];
  end

  assign min_rem = h4_r_q - {6'd0, h4_me_q} * {6'd0, SEC_PER_MIN};

  always_ff @(posedge clk_i) begin
    h5_hour_q <= h4_hour_q;
    h5_me_q   <= h4_me_q;
    h5_r_q    <= min_rem[6:0];
  end

  always_ff @(posedge clk_i) begin
    h6_hour_q <= h5_hour_q;
    if (h5_r_q >= {1'b0, SEC_PER_MIN}) begin
      h6_min_q <= h5_me_q + 6'd1;
      h6_sec_q <= 6'(h5_r_q - {1'b0, SEC_PER_MIN});
    end else begin
      h6_min_q <= h5_me_q;
      h6_sec_q <= h5_r_q[5:0];
    end
  end

  assign valid_o      = vld_q[5];
  assign hms_o.hour   = h6_hour_q;
  assign hms_o.minute = h6_min_q;
  assign hms_o.second = h6_sec_q;

endmodule

### hdl/gwsc_ymd.sv
module gwsc_ymd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic            tv_i,
  input  logic [9:0]      week_i,
  input  logic [3:0]      wday_i,
  output logic            valid_o,
  output gwsc_pkg::date_t date_o
);
  import gwsc_pkg::*;

  logic [6:0]  vld_q;
  logic [6:0]  tv_q;

  logic [13:0] week_ext;
  logic [13:0] total_d;
  logic [13:0] y1_total_q;

  logic [25:0] year_prod;
  logic [13:0] y2_total_q;
  logic [5:0]  y2_ye_q;

  logic [13:0] year_rem;
  logic [5:0]  y3_ye_q;
  logic [9:0]  y3_r_q;

  logic [5:0]  yr4;
  logic [8:0]  r4;
  logic [5:0]  yr4_m1;
  logic [9:0]  y4_doy_q;
  logic [5:0]  y4_yr_q;

  logic        roll;
  logic [5:0]  yr5;
  logic [8:0]  year_len;
  logic [8:0]  y5_doy_q;
  logic [5:0]  y5_yr_q;

  logic        leap5;
  logic [3:0]  cnt;
  logic [8:0]  y6_doy_q;
  logic [5:0]  y6_yr_q;
  logic        y6_leap_q;
  logic [3:0]  y6_month_q;

  logic [8:0]  mday_full;
  logic [11:0] y7_year_q;
  logic [3:0]  y7_month_q;
  logic [4:0]  y7_mday_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tv_q <= {tv_q[5:0], tv_i};
  end

  // Stage 1: days since 1 January 1980 after the fixed week rollover.
  assign week_ext = {4'd0, week_i} + WEEK_ROLLOVER;
  assign total_d  = week_ext * DAYS_IN_WEEK + {10'd0, wday_i} + START_DAY;

  always_ff @(posedge clk_i) begin
    y1_total_q <= total_d;
  end

  // Stage 2: year estimate in common years.
  assign year_prod = {12'd0, y1_total_q} * {14'd0, YEAR_RECIP};

  always_ff @(posedge clk_i) begin
    y2_total_q <= y1_total_q;
    y2_ye_q    <= year_prod[YEAR_SHIFT +: 6];
  end

  assign year_rem = y2_total_q - {8'd0, y2_ye_q} * {5'd0, DAYS_IN_YEAR};

  always_ff @(posedge clk_i) begin
    y3_ye_q <= y2_ye_q;
    y3_r_q  <= year_rem[9:0];
  end

  // Stage 4: finish the division, then take off one day per leap year
  // already passed. The day of year may come out zero or negative here.
  always_comb begin
    if (y3_r_q >= {1'b0, DAYS_IN_YEAR}) begin
      yr4 = y3_ye_q + 6'd1;
      r4  = 9'(y3_r_q - {1'b0, DAYS_IN_YEAR});
    end else begin
      yr4 = y3_ye_q;
      r4  = y3_r_q[8:0];
    end
    yr4_m1 = yr4 - 6'd1;
  end

  always_ff @(posedge clk_i) begin
    y4_yr_q  <= yr4;
    y4_doy_q <= {1'b0, r4} - {6'd0, yr4_m1[5:2]};
  end

  // Stage 5: one rollback into the previous year.
  assign roll     = y4_doy_q[9] || (y4_doy_q == 10'd0);
  assign yr5      = y4_yr_q - 6'd1;
  assign year_len = (yr5[1:0] == 2'b00) ? DAYS_IN_LEAP : DAYS_IN_YEAR;

  always_ff @(posedge clk_i) begin
    if (roll) begin
      y5_yr_q  <= yr5;
      y5_doy_q <= 9'(y4_doy_q + {1'b0, year_len});
    end else begin
      y5_yr_q  <= y4_yr_q;
      y5_doy_q <= y4_doy_q[8:0];
    end
  end

  // Stage 6: the month is one more than the count of month ends passed.
  assign leap5 = (y5_yr_q[1:0] == 2'b00);

  always_comb begin
    cnt = 4'd0;
    for (int m = 1; m <= MONTHS; m++) begin
      cnt = cnt + 4'(y5_doy_q > cum_days(leap5, 4'(m)));
    end
  end

  always_ff @(posedge clk_i) begin
    y6_doy_q   <= y5_doy_q;
    y6_yr_q    <= y5_yr_q;
    y6_leap_q  <= leap5;
    y6_month_q <= cnt + 4'd1;
  end

  assign mday_full = y6_doy_q - cum_days(y6_leap_q, y6_month_q - 4'd1);

  always_ff @(posedge clk_i) begin
    y7_year_q  <= {6'd0, y6_yr_q} + BASE_YEAR;
    y7_month_q <= y6_month_q;
    y7_mday_q  <= mday_full[4:0];
  end

  assign valid_o      = vld_q[6];
  assign date_o.tv    = tv_q[6];
  assign date_o.year  = y7_year_q;
  assign date_o.month = y7_month_q;
  assign date_o.mday  = y7_mday_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int LATENCY = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BEATS = 500;

  // Days before each month, common and leap years.
  localparam int CUM_COMMON [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
  localparam int CUM_LEAP [13] = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366};

  typedef struct packed {
    logic [gwsc_pkg::WEEK_W-1:0]   week;
    logic [gwsc_pkg::SECS_W-1:0]   secs;
    logic [gwsc_pkg::OFFSET_W-1:0] offset;
  } gps_beat_t;

  typedef struct packed {
    logic        tv;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } utc_date_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] week_number = '0;
  logic [19:0] week_seconds = '0;
  logic [7:0] utc_offset = '0;
  logic done_o;
  logic time_valid_o;
  logic [11:0] cal_year_o;
  logic [3:0] cal_month_o;
  logic [4:0] cal_day_o;
  logic [4:0] cal_hour_o;
  logic [5:0] cal_minute_o;
  logic [5:0] cal_second_o;

  gps_beat_t pending_beats[$];
  utc_date_t expected_dates[$];
  gps_beat_t next_beat;
  utc_date_t want_date;
  utc_date_t got_date;

  int sender_idle_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  int valid_dates = 0;
  int invalid_dates = 0;
  int idle_cycles = 0;

  gps_week_seconds_to_calendar_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .week_number_i (week_number),
    .week_seconds_i(week_seconds),
    .utc_offset_i  (utc_offset),
    .done_o        (done_o),
    .time_valid_o  (time_valid_o),
    .cal_year_o    (cal_year_o),
    .cal_month_o   (cal_month_o),
    .cal_day_o     (cal_day_o),
    .cal_hour_o    (cal_hour_o),
    .cal_minute_o  (cal_minute_o),
    .cal_second_o  (cal_second_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Converts GPS week, seconds of week and leap offset to the UTC calendar.
  function automatic utc_date_t calendar_of(gps_beat_t b);
    utc_date_t d;
    int secs;
    int total;
    int yr;
    int doy;
    int mon;
    int cum [13];
    d = '0;
    secs = int'(b.secs) - int'(b.offset);
    if (secs < 0) begin
      return d;
    end
    d.hour = 5'((secs % 86400) / 3600);
    d.minute = 6'((secs % 3600) / 60);
    d.second = 6'(secs % 60);
    total = (int'(b.week) + 1024) * 7 + secs / 86400 + 5;
    yr = total / 365;
    doy = total - yr * 365 + 1 - ((yr - 1) / 4 + 1);
    if (doy <= 0) begin
      yr = yr - 1;
      doy = doy + ((yr % 4 != 0) ? 365 : 366);
    end
    if (yr % 4 != 0) begin
      cum = CUM_COMMON;
    end else begin
      cum = CUM_LEAP;
    end
    mon = 1;
    while (mon < 13 && doy > cum[mon]) begin
      mon++;
    end
    d.tv = 1'b1;
    d.year = 12'(yr + 1980);
    d.month = 4'(mon);
    d.mday = 5'(doy - cum[mon - 1]);
    return d;
  endfunction

  task automatic note_failure(string msg, utc_date_t want, utc_date_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s: expected v=%0b %0d-%0d-%0d %0d:%0d:%0d, got v=%0b %0d-%0d-%0d %0d:%0d:%0d",
               $realtime, msg, want.tv, want.year, want.month, want.mday, want.hour,
               want.minute, want.second, got.tv, got.year, got.month, got.mday, got.hour,
               got.minute, got.second);
    end
  endtask

  function automatic gps_beat_t random_beat();
    gps_beat_t b;
    int pick;
    pick = $urandom_range(99);
    b.week = 10'($urandom_range(1023));
    if (pick < 78) begin
      b.secs = 20'($urandom_range(604799));
      b.offset = 8'($urandom_range(255));
    end else if (pick < 90) begin
      // Seconds past the end of the week roll into the following days.
      b.secs = 20'($urandom_range(1048575, 604800));
      b.offset = 8'($urandom_range(255));
    end else begin
      b.offset = 8'($urandom_range(255, 1));
      b.secs = 20'($urandom_range(int'(b.offset) - 1));
    end
    return b;
  endfunction

  // Driver: a beat is taken when start is high and busy is low.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        beats_sent++;
        expected_dates.push_back(calendar_of('{week_number, week_seconds, utc_offset}));
      end
      if (!start || !busy) begin
        if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_beat = pending_beats.pop_front();
          week_number <= next_beat.week;
          week_seconds <= next_beat.secs;
          utc_offset <= next_beat.offset;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe must match the oldest expected date.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_date = '{time_valid_o, cal_year_o, cal_month_o, cal_day_o, cal_hour_o,
                   cal_minute_o, cal_second_o};
      if (time_valid_o) begin
        valid_dates++;
      end else begin
        invalid_dates++;
      end
      if (expected_dates.size() == 0) begin
        note_failure("result with no beat outstanding", '0, got_date);
      end else begin
        want_date = expected_dates.pop_front();
        if (got_date.tv !== want_date.tv || got_date.year !== want_date.year ||
            got_date.month !== want_date.month || got_date.mday !== want_date.mday ||
            got_date.hour !== want_date.hour || got_date.minute !== want_date.minute ||
            got_date.second !== want_date.second) begin
          note_failure("date mismatch", want_date, got_date);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_dates.size());
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    gps_beat_t b;
    utc_date_t d;
    bit got_rollback;
    bit got_leap_day;
    bit got_leap_eve;
    bit got_common_eve;
    bit got_march_first;
    int total;
    int yr;
    int doy;

    got_rollback = 1'b0;
    got_leap_day = 1'b0;
    got_leap_eve = 1'b0;
    got_common_eve = 1'b0;
    got_march_first = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Field extremes, the invalid boundary and seconds beyond one week.
    pending_beats.push_back('{10'd0, 20'd0, 8'd0});
    pending_beats.push_back('{10'd1023, 20'd604799, 8'd0});
    pending_beats.push_back('{10'd1023, 20'hFFFFF, 8'd0});
    pending_beats.push_back('{10'd0, 20'hFFFFF, 8'd255});
    pending_beats.push_back('{10'd512, 20'd0, 8'd255});
    pending_beats.push_back('{10'd0, 20'd254, 8'd255});
    pending_beats.push_back('{10'd0, 20'd255, 8'd255});
    pending_beats.push_back('{10'd1023, 20'd0, 8'd1});
    pending_beats.push_back('{10'd341, 20'd86399, 8'd0});
    pending_beats.push_back('{10'd682, 20'd86400, 8'd18});
    pending_beats.push_back('{10'h2AA, 20'hAAAAA, 8'h55});
    pending_beats.push_back('{10'h155, 20'h55555, 8'hAA});
    pending_beats.push_back('{10'd1023, 20'd604800, 8'd0});

    // Hunt for calendar corners: the year rollback, leap day, year ends, March first.
    for (int w = 0; w < 1024; w++) begin
      for (int dd = 0; dd < 7; dd++) begin
        b.week = 10'(w);
        b.secs = 20'(dd * 86400 + $urandom_range(86399));
        b.offset = 8'd0;
        d = calendar_of(b);
        total = (w + 1024) * 7 + dd + 5;
        yr = total / 365;
        doy = total - yr * 365 + 1 - ((yr - 1) / 4 + 1);
        if (!got_rollback && doy <= 0) begin
          got_rollback = 1'b1;
          pending_beats.push_back(b);
        end
        if (!got_leap_day && d.month == 2 && d.mday == 29) begin
          got_leap_day = 1'b1;
          pending_beats.push_back(b);
        end
        if (d.month == 12 && d.mday == 31) begin
          if (!got_leap_eve && d.year % 4 == 0) begin
            got_leap_eve = 1'b1;
            pending_beats.push_back(b);
          end else if (!got_common_eve && d.year % 4 != 0) begin
            got_common_eve = 1'b1;
            pending_beats.push_back(b);
          end
        end
        if (!got_march_first && d.month == 3 && d.mday == 1 && d.year % 4 == 0) begin
          got_march_first = 1'b1;
          pending_beats.push_back(b);
        end
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 54 : 0;
      for (int n = 0; n < RANDOM_BEATS / 3; n++) begin
        pending_beats.push_back(random_beat());
      end
      // The sender holds off between phases until every result is back.
      while (pending_beats.size() != 0 || start || expected_dates.size() != 0) begin
        @(negedge clk_i);
      end
    end

    repeat (LATENCY + 8) @(negedge clk_i);
    if (expected_dates.size() != 0) begin
      note_failure("results never arrived", expected_dates[0], '0);
    end

    $display("Sent %0d beats over three idle profiles; checked %0d valid and %0d invalid dates.",
             beats_sent, valid_dates, invalid_dates);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
